[rtl/mpc_pkg.sv]
// Package for the GF(2) matrix product check.
// Holds widths, command and select codes and the sequencer state type.
// No dependencies.
package mpc_pkg;

  // Width of one stored matrix row and of the random vector.
  localparam int RowW = 64;
  // Width of the matrix size register.
  localparam int SizeW = 7;
  // Default number of rows in the row stores.
  localparam int MaxSizeDef = 64;
  // Matrix size after reset.
  localparam logic [SizeW-1:0] SizeReset = 7'd64;

  // Request codes.
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdCheck = 1'b1;

  // Load targets.
  localparam logic [1:0] SelA = 2'd0;
  localparam logic [1:0] SelB = 2'd1;
  localparam logic [1:0] SelC = 2'd2;

  // Check sequencer states.
  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StBRows  = 4'b0010,
    StACRows = 4'b0100,
    StFinish = 4'b1000
  } state_e;

endpackage

[rtl/mpc_ram.sv]
// Generic single-port RAM with registered read data.
// Used for the A, B and C row stores. No dependencies.
module mpc_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                           wdata_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write on enable, read every cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/matrix_product_check_gf2.sv]
// Freivalds matrix product check over GF(2), A(Br) == Cr; uses mpc_pkg and mpc_ram.
// A load request is written at the accepting edge and busy stays low. A check reads
// one row per cycle, first all n B rows, then A and C rows together (n = rows in use):
// the done strobe follows the finish state and busy_o drops with it, so no new
// request is taken before the done strobe. The receiver cannot stall.
// Reset clears the sequencer and sets the size to 64; row contents persist.
module matrix_product_check_gf2 #(
  parameter int MaxSize = mpc_pkg::MaxSizeDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Request channel
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      cmd_i,
  input  logic [1:0]                matrix_select_i,
  input  logic [5:0]                row_index_i,
  input  logic [mpc_pkg::RowW-1:0]  row_bits_i,
  input  logic [mpc_pkg::RowW-1:0]  random_vector_i,
  // Result
  output logic                      done_o,
  output logic                      products_equal_o,
  // Size register write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mpc_pkg::SizeW-1:0] cfg_data_i
);

  localparam int AddrW = (MaxSize > 1) ? $clog2(MaxSize) : 1;
  localparam int RowW  = mpc_pkg::RowW;
  localparam int SizeW = mpc_pkg::SizeW;

  mpc_pkg::state_e state_q, state_d;

  logic [SizeW-1:0]   size_q;
  logic [SizeW-1:0]   n_eff;
  logic [RowW-1:0]    mask_now;
  logic [RowW-1:0]    mask_q, mask_d;
  logic [RowW-1:0]    r_q, r_d;
  logic [AddrW-1:0]   last_q, last_d;
  logic [AddrW-1:0]   addr_q, addr_d;
  logic [MaxSize-1:0] br_q, br_d;
  logic               diff_q, diff_d;
  logic               rd_vld_q, rd_vld_d;
  logic               rd_b_q, rd_b_d;
  logic [AddrW-1:0]   rd_idx_q, rd_idx_d;
  logic               done_q, done_d;
  logic               eq_q, eq_d;

  logic               accept;
  logic               load_ok;
  logic [AddrW-1:0]   mem_addr;
  logic               we_a, we_b, we_c;
  logic [RowW-1:0]    a_rdata, b_rdata, c_rdata;
  logic [RowW-1:0]    br_ext;
  logic               b_par;
  logic               row_mismatch;

  assign accept      = start_i & ~busy_o;
  assign busy_o      = (state_q != mpc_pkg::StIdle);
  assign cfg_ready_o = 1'b1;

  // Size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= mpc_pkg::SizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_data_i;
    end
  end

  // Clamp the size to 1..MaxSize and build the column mask
  always_comb begin
    if (size_q == '0) begin
      n_eff = SizeW'(1);
    end else if (size_q > SizeW'(MaxSize)) begin
      n_eff = SizeW'(MaxSize);
    end else begin
      n_eff = size_q;
    end
    for (int j = 0; j < RowW; j++) begin
      mask_now[j] = (SizeW'(j) < n_eff);
    end
  end

  // Load writes go straight to the row stores
  assign load_ok = accept && (cmd_i == mpc_pkg::CmdLoad) &&
                   ({1'b0, row_index_i} < SizeW'(MaxSize));
  assign we_a = load_ok && (matrix_select_i == mpc_pkg::SelA);
  assign we_b = load_ok && (matrix_select_i == mpc_pkg::SelB);
  assign we_c = load_ok && (matrix_select_i == mpc_pkg::SelC);
  assign mem_addr = busy_o ? addr_q : row_index_i[AddrW-1:0];

  mpc_ram #(.Width(RowW), .Depth(MaxSize)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .addr_i  (mem_addr),
    .wdata_i (row_bits_i),
    .rdata_o (a_rdata)
  );

  mpc_ram #(.Width(RowW), .Depth(MaxSize)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .addr_i  (mem_addr),
    .wdata_i (row_bits_i),
    .rdata_o (b_rdata)
  );

  mpc_ram #(.Width(RowW), .Depth(MaxSize)) u_ram_c (
    .clk_i   (clk_i),
    .we_i    (we_c),
    .addr_i  (mem_addr),
    .wdata_i (row_bits_i),
    .rdata_o (c_rdata)
  );

  // Row parities on the data returned from the stores
  assign br_ext       = RowW'(br_q);
  assign b_par        = ^(b_rdata & r_q & mask_q);
  assign row_mismatch = (^(a_rdata & br_ext & mask_q)) ^ (^(c_rdata & r_q & mask_q));

  // Sequencer: issue one row read per cycle, fold returned rows
  always_comb begin
    state_d  = state_q;
    mask_d   = mask_q;
    r_d      = r_q;
    last_d   = last_q;
    addr_d   = addr_q;
    br_d     = br_q;
    diff_d   = diff_q;
    rd_vld_d = 1'b0;
    rd_b_d   = rd_b_q;
    rd_idx_d = addr_q;
    done_d   = 1'b0;
    eq_d     = eq_q;

    // Fold the row read in the previous cycle
    if (rd_vld_q) begin
      if (rd_b_q) begin
        br_d[rd_idx_q] = b_par;
      end else begin
        diff_d = diff_q | row_mismatch;
      end
    end

    unique case (state_q)
      mpc_pkg::StIdle: begin
        if (accept && (cmd_i == mpc_pkg::CmdCheck)) begin
          mask_d  = mask_now;
          r_d     = random_vector_i;
          last_d  = AddrW'(n_eff - SizeW'(1));
          addr_d  = '0;
          br_d    = '0;
          diff_d  = 1'b0;
          state_d = mpc_pkg::StBRows;
        end
      end
      mpc_pkg::StBRows: begin
        rd_vld_d = 1'b1;
        rd_b_d   = 1'b1;
        if (addr_q == last_q) begin
          addr_d  = '0;
          state_d = mpc_pkg::StACRows;
        end else begin
          addr_d = addr_q + AddrW'(1);
        end
      end
      mpc_pkg::StACRows: begin
        rd_vld_d = 1'b1;
        rd_b_d   = 1'b0;
        if (addr_q == last_q) begin
          state_d = mpc_pkg::StFinish;
        end else begin
          addr_d = addr_q + AddrW'(1);
        end
      end
      mpc_pkg::StFinish: begin
        // Last A/C row is folded this cycle
        done_d  = 1'b1;
        eq_d    = ~diff_d;
        state_d = mpc_pkg::StIdle;
      end
      default: begin
        state_d = mpc_pkg::StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mpc_pkg::StIdle;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mask_q   <= mask_d;
    r_q      <= r_d;
    last_q   <= last_d;
    addr_q   <= addr_d;
    br_q     <= br_d;
    diff_q   <= diff_d;
    rd_b_q   <= rd_b_d;
    rd_idx_q <= rd_idx_d;
    eq_q     <= eq_d;
  end

  assign done_o           = done_q;
  assign products_equal_o = eq_q;

endmodule

[verif/matrix_product_check_gf2_tb.sv]
`timescale 1ns / 1ps
// Testbench for matrix_product_check_gf2: row loads, size writes and checks,
// scored against an in-bench GF(2) product predictor. Depends on mpc_pkg.
module matrix_product_check_gf2_tb;

  localparam int Rows = mpc_pkg::MaxSizeDef;
  // Load target that the block ignores.
  localparam logic [1:0] SelNone = 2'd3;

  typedef logic [mpc_pkg::RowW-1:0] row_t;
  typedef row_t matrix_t [Rows];

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      cmd_i = mpc_pkg::CmdLoad;
  logic [1:0]                matrix_select_i = mpc_pkg::SelA;
  logic [5:0]                row_index_i = '0;
  row_t                      row_bits_i = '0;
  row_t                      random_vector_i = '0;
  logic                      cfg_valid_i = 1'b0;
  logic [mpc_pkg::SizeW-1:0] cfg_data_i = '0;
  logic                      busy_o;
  logic                      done_o;
  logic                      products_equal_o;
  logic                      cfg_ready_o;

  // Shadow copy of the row stores and the size register.
  matrix_t                   mat_a;
  matrix_t                   mat_b;
  matrix_t                   mat_c;
  logic [mpc_pkg::SizeW-1:0] size_shadow = mpc_pkg::SizeReset;
  // Expected equal flags, one per accepted check.
  logic                      equal_flags_q [$];
  int                        fail_cnt = 0;
  int                        idle_pct = 0;
  int                        items_sent = 0;

  matrix_product_check_gf2 u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .cmd_i            (cmd_i),
    .matrix_select_i  (matrix_select_i),
    .row_index_i      (row_index_i),
    .row_bits_i       (row_bits_i),
    .random_vector_i  (random_vector_i),
    .done_o           (done_o),
    .products_equal_o (products_equal_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Clamp the size register to the rows that take part in a check.
  function automatic int used_rows(logic [mpc_pkg::SizeW-1:0] sz);
    if (sz == 0) return 1;
    if (sz > Rows) return Rows;
    return int'(sz);
  endfunction

  function automatic row_t used_mask(int n);
    if (n >= mpc_pkg::RowW) return '1;
    return (row_t'(1) << n) - 1;
  endfunction

  // Entry i is the parity of row i ANDed with the vector, over the used bits.
  function automatic row_t gf2_mat_times_vec(matrix_t m, int n, row_t v, row_t mask);
    row_t res;
    res = '0;
    for (int i = 0; i < n; i++) res[i] = ^(m[i] & v & mask);
    return res;
  endfunction

  // Compare A(Br) with Cr for the current shadow state.
  function automatic logic predict_equal(row_t r);
    int   n;
    row_t mask;
    row_t br;
    n    = used_rows(size_shadow);
    mask = used_mask(n);
    br   = gf2_mat_times_vec(mat_b, n, r, mask);
    return gf2_mat_times_vec(mat_a, n, br, mask) == gf2_mat_times_vec(mat_c, n, r, mask);
  endfunction

  function automatic row_t rand_row();
    return {$urandom, $urandom};
  endfunction

  function automatic row_t pick_vector();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    return rand_row();
  endfunction

  // Drive one request and hold it until the block takes it.
  task automatic send_request(input logic cmd, input logic [1:0] sel, input logic [5:0] row,
                              input row_t bits, input row_t r);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i         <= 1'b1;
    cmd_i           <= cmd;
    matrix_select_i <= sel;
    row_index_i     <= row;
    row_bits_i      <= bits;
    random_vector_i <= r;
    do @(posedge clk_i); while (busy_o);
    // Update the shadow state on accept.
    if (cmd == mpc_pkg::CmdCheck) begin
      equal_flags_q.push_back(predict_equal(r));
    end else begin
      case (sel)
        mpc_pkg::SelA: mat_a[row] = bits;
        mpc_pkg::SelB: mat_b[row] = bits;
        mpc_pkg::SelC: mat_c[row] = bits;
        default: ;
      endcase
    end
    if (!(cmd == mpc_pkg::CmdLoad && sel == SelNone)) items_sent++;
  endtask

  task automatic load_row(input logic [1:0] sel, input int row, input row_t bits);
    send_request(mpc_pkg::CmdLoad, sel, 6'(row), bits, rand_row());
  endtask

  task automatic run_check(input row_t r);
    send_request(mpc_pkg::CmdCheck, 2'($urandom), 6'($urandom), rand_row(), r);
  endtask

  // Hold requests off until every check has reported and the last load retired.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (equal_flags_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [mpc_pkg::SizeW-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    size_shadow = value;
  endtask

  // Load a request the block drops, a row outside the size, or a garbage row.
  task automatic load_stray_row(input int n);
    int roll;
    roll = $urandom_range(99);
    if (roll < 40 || n >= Rows) begin
      load_row(SelNone, $urandom_range(Rows - 1), rand_row());
    end else if (roll < 80) begin
      load_row(2'($urandom_range(2)), $urandom_range(Rows - 1, n), rand_row());
    end else begin
      load_row(2'($urandom_range(2)), $urandom_range(n - 1), rand_row());
    end
  endtask

  // Load random A and B over n rows and C = AB, junk above the used bits,
  // optionally with one entry of C flipped and stray loads mixed in.
  task automatic load_product_set(input int n, input bit corrupt, input int noise_pct);
    matrix_t a;
    matrix_t b;
    matrix_t c;
    row_t    mask;
    int      ci;
    int      cj;
    mask = used_mask(n);
    for (int i = 0; i < n; i++) begin
      a[i] = rand_row();
      b[i] = rand_row();
    end
    for (int i = 0; i < n; i++) begin
      c[i] = rand_row() & ~mask;
      for (int k = 0; k < n; k++) begin
        if (a[i][k]) c[i] ^= b[k] & mask;
      end
    end
    if (corrupt) begin
      ci = $urandom_range(n - 1);
      cj = $urandom_range(n - 1);
      c[ci][cj] = ~c[ci][cj];
    end
    for (int i = 0; i < n; i++) begin
      load_row(mpc_pkg::SelA, i, a[i]);
      load_row(mpc_pkg::SelB, i, b[i]);
      load_row(mpc_pkg::SelC, i, c[i]);
      if ($urandom_range(99) < noise_pct) load_stray_row(n);
    end
  endtask

  // One-row matrices: all-ones and all-zero vectors, bits above the size,
  // ignored select, size zero, then a two-row product.
  task automatic test_single_row_size();
    write_size(7'd1);
    load_row(mpc_pkg::SelA, 0, '1);
    load_row(mpc_pkg::SelB, 0, '1);
    load_row(mpc_pkg::SelC, 0, '1);
    run_check('1);
    run_check('0);
    // clear bit 0 of C so Cr differs whenever r has bit 0 set
    load_row(mpc_pkg::SelC, 0, ~row_t'(1));
    run_check('1);
    run_check(~row_t'(1));
    // the dropped select must leave C as it was
    load_row(SelNone, 0, '1);
    run_check('1);
    write_size(7'd0);
    run_check(row_t'(1));
    write_size(7'd2);
    load_product_set(2, 1'b0, 0);
    run_check('1);
    run_check(rand_row());
  endtask

  // Full 64x64 product, size above the store, flipped corner entry.
  task automatic test_full_size_product();
    write_size(7'd127);
    load_product_set(Rows, 1'b0, 0);
    run_check('1);
    run_check(rand_row());
    run_check('0);
    load_row(mpc_pkg::SelC, Rows - 1, mat_c[Rows - 1] ^ (row_t'(1) << (Rows - 1)));
    run_check('1);
    write_size(7'd64);
    run_check(row_t'(1) << (Rows - 1));
    run_check(rand_row());
    // shrink by one so the flipped entry drops out
    write_size(7'(Rows - 1));
    run_check('1);
  endtask

  // Random product sets and checks; mostly small sizes, large ones not kept.
  task automatic test_random_products(input int pct, input int budget);
    int                        stop_at;
    int                        roll;
    logic [mpc_pkg::SizeW-1:0] sz;
    idle_pct = pct;
    stop_at  = items_sent + budget;
    while (items_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 30 || used_rows(size_shadow) > 16) begin
        roll = $urandom_range(99);
        if (roll < 65) sz = mpc_pkg::SizeW'($urandom_range(8));
        else if (roll < 90) sz = mpc_pkg::SizeW'($urandom_range(32, 9));
        else if (roll < 96) sz = mpc_pkg::SizeW'($urandom_range(63, 33));
        else sz = mpc_pkg::SizeW'($urandom_range(127, 64));
        write_size(sz);
      end
      load_product_set(used_rows(size_shadow), $urandom_range(99) < 30, 10);
      repeat ($urandom_range(6, 1)) begin
        if ($urandom_range(7) == 0) wait_idle();
        run_check(pick_vector());
      end
    end
  endtask

  // Score every done strobe against the oldest expected flag.
  always @(posedge clk_i) begin : score_results
    logic want;
    if (rst_ni && done_o) begin
      if (equal_flags_q.size() == 0) begin
        $error("products_equal: expected no result, actual %0b", products_equal_o);
        fail_cnt++;
      end else begin
        want = equal_flags_q.pop_front();
        if (products_equal_o !== want) begin
          $error("products_equal: expected %0b, actual %0b", want, products_equal_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_row_size();
    test_full_size_product();
    test_random_products(0, 180);
    test_random_products(87, 180);
    test_random_products(12, 170);
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("matrix_product_check_gf2_tb OK");
    end else begin
      $display("matrix_product_check_gf2_tb NOT OK");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #2_000_000;
    $display("matrix_product_check_gf2_tb NOT OK");
    $finish;
  end

endmodule

[sim.f]
rtl/mpc_pkg.sv
rtl/mpc_ram.sv
rtl/matrix_product_check_gf2.sv
verif/matrix_product_check_gf2_tb.sv
